>>> src/lomc_pkg.sv
package lomc_pkg;

    localparam int ENTRIES    = 8;
    localparam int STAMP_BITS = 32;
    localparam int ID_W       = 32;
    localparam int SLOT_W     = 3;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int ENTRY_W    = ID_W + STAMP_BITS;

    localparam int IN_BITS    = ID_W + 1;
    localparam int S_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = 1 + SLOT_W + 1 + ID_W + ID_W;
    localparam int M_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [ID_W-1:0]       t_id;
    typedef logic [STAMP_BITS-1:0] t_stamp;

    typedef enum logic [0:0] {
        ACT_ACTIVATE = 1'b0,
        ACT_CLOSE    = 1'b1
    } t_action;

    typedef enum logic [0:0] {
        ST_OK    = 1'b0,
        ST_NOMAP = 1'b1
    } t_status;

    typedef struct packed {
        logic clr;
        logic proc;
        t_idx idx;
        logic vld;
    } t_scan_ctl;

    typedef struct packed {
        logic match;
        logic hit;
        t_idx hit_idx;
        logic hit0;
        t_idx cand_idx;
        t_id  cand_id;
    } t_scan_res;

    function automatic logic [SLOT_W-1:0] slot_bits(input t_idx idx);
        logic [IDX_W+SLOT_W-1:0] ext;
        ext = {{SLOT_W{1'b0}}, idx};
        return ext[SLOT_W-1:0];
    endfunction

endpackage

>>> src/lru_open_map_cache.sv
// An activate of the already active id, or any request with id zero, skips the
// scan; other requests scan the slots, one entry read per cycle, and an activate
// stops early on a hit above slot 0. One item at a time: no new input beat is
// taken until the result beat has been loaded into the output register.
// Reset (i_rst_n low, synchronous): all slots empty, stamp, active id and
// active slot cleared. No clearing pass; per-slot valid bits reset at once.
module lru_open_map_cache (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [31:0] map_id, [32] open_ok
    input  logic [lomc_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    // [0] action
    input  logic                              i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [0] status, [3:1] slot, [4] evicted_valid, [36:5] evicted_id,
    // [68:37] active_id
    output logic [lomc_pkg::M_TDATA_W-1:0]    o_m_axis_tdata
);
    import lomc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_step, n_step;
    t_idx               r_dat_idx;
    logic [ENTRIES-1:0] r_vld, n_vld;
    t_stamp             r_stamp, n_stamp;
    t_id                r_active_map, n_active_map;
    t_idx               r_active_slot, n_active_slot;
    logic               r_found, n_found;
    logic               r_out_valid, n_out_valid;

    t_id                r_id;
    t_action            r_act;
    logic               r_ok;
    logic               r_quick;
    t_status            r_qstat;
    logic [OUT_BITS-1:0] r_out, n_out;
    logic               out_load;

    t_id                in_id;
    t_stamp             bump;
    logic [CNT_W-1:0]   back;
    t_idx               rd_addr;
    logic               in_acc;
    logic               out_free;
    logic               hit;
    t_idx               hit_slot;

    logic               ram_we;
    t_idx               ram_waddr;
    logic [ENTRY_W-1:0] ram_rdata;

    t_scan_ctl          scan_ctl;
    t_scan_res          scan_res;

    t_status            o_status;
    logic               o_ev_valid;
    t_id                o_ev_id;

    assign in_id    = i_s_axis_tdata[ID_W-1:0];
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign bump     = r_stamp + 1'b1;
    assign back     = CNT_W'(ENTRIES) - r_step;
    assign rd_addr  = (r_step == '0) ? '0 : back[IDX_W-1:0];
    assign hit      = scan_res.hit || scan_res.hit0;
    assign hit_slot = scan_res.hit ? scan_res.hit_idx : '0;

    assign scan_ctl.clr  = in_acc;
    assign scan_ctl.proc = (r_state == S_SCAN) && (r_step != '0);
    assign scan_ctl.idx  = r_dat_idx;
    assign scan_ctl.vld  = r_vld[r_dat_idx];

    lomc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({r_id, r_stamp}),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    lomc_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (scan_ctl),
        .i_id      (r_id),
        .i_rd_data (ram_rdata),
        .o_res     (scan_res)
    );

    always_comb begin
        n_state       = r_state;
        n_step        = r_step;
        n_vld         = r_vld;
        n_stamp       = r_stamp;
        n_active_map  = r_active_map;
        n_active_slot = r_active_slot;
        n_found       = r_found;
        n_out_valid   = r_out_valid && !i_m_axis_tready;
        out_load      = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = scan_res.cand_idx;
        o_status      = ST_OK;
        o_ev_valid    = 1'b0;
        o_ev_id       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_step  = '0;
                    n_found = 1'b0;
                    if (t_action'(i_s_axis_tuser) == ACT_ACTIVATE) begin
                        if (r_active_map == in_id || in_id == '0) begin
                            n_state = S_UPD;
                        end else begin
                            n_state = S_SCAN;
                            n_stamp = bump;
                            if (bump == '0) begin
                                // stamp wrapped: flush everything, skip zero
                                n_stamp       = t_stamp'(1);
                                n_vld         = '0;
                                n_active_map  = '0;
                                n_active_slot = '0;
                            end
                        end
                    end else begin
                        n_state = (in_id == '0) ? S_UPD : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_step = r_step + 1'b1;
                if (scan_ctl.proc) begin
                    if (r_act == ACT_CLOSE && scan_res.match) begin
                        n_vld[r_dat_idx] = 1'b0;
                        n_found          = 1'b1;
                    end
                    if ((r_act == ACT_ACTIVATE && scan_res.match && r_dat_idx != '0)
                        || r_step == CNT_W'(ENTRIES)) begin
                        n_state = S_UPD;
                    end
                end
            end
            S_UPD: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_quick) begin
                        o_status = r_qstat;
                    end else if (r_act == ACT_CLOSE) begin
                        o_ev_valid = r_found;
                        o_ev_id    = r_found ? r_id : '0;
                    end else if (hit) begin
                        ram_we        = 1'b1;
                        ram_waddr     = hit_slot;
                        n_active_map  = r_id;
                        n_active_slot = hit_slot;
                    end else begin
                        o_ev_valid = (scan_res.cand_id != '0);
                        o_ev_id    = scan_res.cand_id;
                        if (o_ev_valid && scan_res.cand_id == r_active_map) begin
                            n_active_map = '0;
                        end
                        if (r_ok) begin
                            ram_we                   = 1'b1;
                            n_vld[scan_res.cand_idx] = 1'b1;
                            n_active_map             = r_id;
                            n_active_slot            = scan_res.cand_idx;
                        end else begin
                            n_vld[scan_res.cand_idx] = 1'b0;
                            o_status                 = ST_NOMAP;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out = {n_active_map, o_ev_id, o_ev_valid, slot_bits(n_active_slot), o_status};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_step        <= '0;
            r_vld         <= '0;
            r_stamp       <= '0;
            r_active_map  <= '0;
            r_active_slot <= '0;
            r_found       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_step        <= n_step;
            r_vld         <= n_vld;
            r_stamp       <= n_stamp;
            r_active_map  <= n_active_map;
            r_active_slot <= n_active_slot;
            r_found       <= n_found;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dat_idx <= rd_addr;
        if (in_acc) begin
            r_id    <= in_id;
            r_act   <= t_action'(i_s_axis_tuser);
            r_ok    <= i_s_axis_tdata[ID_W];
            r_quick <= (in_id == '0)
                       || (t_action'(i_s_axis_tuser) == ACT_ACTIVATE && r_active_map == in_id);
            r_qstat <= (t_action'(i_s_axis_tuser) == ACT_ACTIVATE
                        && r_active_map != in_id) ? ST_NOMAP : ST_OK;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(M_TDATA_W - OUT_BITS){1'b0}}, r_out};

    a_stamp_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_act == ACT_ACTIVATE) |-> (r_stamp != '0))
        else $error("access stamp is zero during an activate scan");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_step <= CNT_W'(ENTRIES)))
        else $error("scan ran past the last entry");

    a_evict_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out[1 + SLOT_W] && r_out[1 + SLOT_W + ID_W -: ID_W] == '0))
        else $error("eviction reported with empty id");

    a_ok_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && !r_quick && r_act == ACT_ACTIVATE && o_status == ST_OK)
        |=> (r_out[OUT_BITS-1 -: ID_W] == $past(r_id)))
        else $error("activate answered OK without making the id active");

endmodule

>>> src/lomc_ram.sv
module lomc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/lomc_scan.sv
module lomc_scan (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lomc_pkg::t_scan_ctl              i_ctl,
    input  lomc_pkg::t_id                    i_id,
    input  logic [lomc_pkg::ENTRY_W-1:0]     i_rd_data,
    output lomc_pkg::t_scan_res              o_res
);
    import lomc_pkg::*;

    t_id    rd_id;
    t_id    eff_id;
    t_stamp eff_stamp;
    logic   match;

    logic   r_hit;
    logic   r_hit0;
    t_idx   r_hit_idx;
    t_idx   r_cand_idx;
    t_id    r_cand_id;
    t_stamp r_cand_stamp;

    // invalid slots read as empty: id 0, stamp 0
    assign rd_id     = i_rd_data[ENTRY_W-1 -: ID_W];
    assign eff_id    = i_ctl.vld ? rd_id : '0;
    assign eff_stamp = i_ctl.vld ? i_rd_data[STAMP_BITS-1:0] : '0;
    assign match     = i_ctl.proc && i_ctl.vld && (rd_id == i_id);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit  <= 1'b0;
            r_hit0 <= 1'b0;
        end else if (i_ctl.clr) begin
            r_hit  <= 1'b0;
            r_hit0 <= 1'b0;
        end else if (i_ctl.proc) begin
            if (i_ctl.idx == '0) begin
                r_hit0 <= match;
            end else if (match) begin
                r_hit <= 1'b1;
            end
        end
    end

    // slot 0 is always the first beat of a scan and seeds the candidate
    always_ff @(posedge i_clk) begin
        if (i_ctl.proc) begin
            if (i_ctl.idx == '0) begin
                r_cand_idx   <= '0;
                r_cand_id    <= eff_id;
                r_cand_stamp <= eff_stamp;
            end else if (match) begin
                if (!r_hit) begin
                    r_hit_idx <= i_ctl.idx;
                end
            end else if (eff_stamp < r_cand_stamp) begin
                r_cand_idx   <= i_ctl.idx;
                r_cand_id    <= eff_id;
                r_cand_stamp <= eff_stamp;
            end
        end
    end

    always_comb begin
        o_res.match    = match;
        o_res.hit      = r_hit;
        o_res.hit_idx  = r_hit_idx;
        o_res.hit0     = r_hit0;
        o_res.cand_idx = r_cand_idx;
        o_res.cand_id  = r_cand_id;
    end

endmodule

>>> sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lomc_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 30;
    localparam int POOL_SIZE   = 12;

    typedef struct {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic              ev_valid;
        t_id               ev_id;
        t_id               active;
    } t_map_answer;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // mirror of the cache contents
    t_id        cache_id[ENTRIES];
    t_stamp     cache_stamp[ENTRIES];
    t_stamp     use_stamp;
    t_id        cur_map;
    t_idx       cur_slot;

    t_map_answer expected_answers[$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          idle_on = 1'b1;
    bit          rx_hold_req = 1'b0;

    lru_open_map_cache DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // [31:0] map_id, [32] open_ok
        .i_s_axis_tuser  (s_tuser),   // [0] action
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        // [0] status, [3:1] slot, [4] evicted_valid, [36:5] evicted_id, [68:37] active_id
        .o_m_axis_tdata  (m_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic t_id fresh_id();
        t_id id;
        do id = $urandom(); while (id == '0);
        return id;
    endfunction

    function automatic void flush_cache();
        foreach (cache_id[i]) begin
            cache_id[i]    = '0;
            cache_stamp[i] = '0;
        end
        cur_map  = '0;
        cur_slot = '0;
    endfunction

    function automatic t_map_answer predict_map_request(t_action act, t_id id, logic ok);
        t_map_answer a;
        t_stamp      stamp;
        t_idx        oldest;
        bit          hit;
        a.status   = ST_OK;
        a.ev_valid = 1'b0;
        a.ev_id    = '0;
        if (act == ACT_CLOSE) begin
            if (id != '0) begin
                for (int i = ENTRIES - 1; i >= 0; i--) begin
                    if (cache_id[i] == id) begin
                        cache_id[i]    = '0;
                        cache_stamp[i] = '0;
                        a.ev_valid     = 1'b1;
                        a.ev_id        = id;
                    end
                end
            end
        end else if (cur_map == id) begin
            a.status = ST_OK;
        end else if (id == '0) begin
            a.status = ST_NOMAP;
        end else begin
            use_stamp = use_stamp + 1'b1;
            if (use_stamp == '0) begin
                flush_cache();
                use_stamp = use_stamp + 1'b1;
            end
            stamp  = use_stamp;
            oldest = '0;
            hit    = 1'b0;
            for (int i = ENTRIES - 1; i >= 0; i--) begin
                if (!hit) begin
                    if (cache_id[i] == id) begin
                        cache_stamp[i] = stamp;
                        cur_map        = id;
                        cur_slot       = t_idx'(i);
                        hit            = 1'b1;
                    end else if (cache_stamp[i] < cache_stamp[oldest]) begin
                        oldest = t_idx'(i);
                    end
                end
            end
            if (!hit) begin
                if (cache_id[oldest] != '0) begin
                    a.ev_valid = 1'b1;
                    a.ev_id    = cache_id[oldest];
                    if (a.ev_id == cur_map) begin
                        cur_map = '0;
                    end
                    cache_id[oldest]    = '0;
                    cache_stamp[oldest] = '0;
                end
                if (ok) begin
                    cache_id[oldest]    = id;
                    cache_stamp[oldest] = stamp;
                    cur_map             = id;
                    cur_slot            = oldest;
                end else begin
                    a.status = ST_NOMAP;
                end
            end
        end
        a.slot   = SLOT_W'(cur_slot);
        a.active = cur_map;
        return a;
    endfunction

    task automatic send_request(input t_action act, input t_id id, input logic ok);
        int gap;
        gap = idle_on ? gap_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(S_TDATA_W - IN_BITS){1'b0}}, ok, id};
        do @(posedge i_clk); while (!s_tready);
        expected_answers.push_back(predict_map_request(act, id, ok));
    endtask

    initial begin : result_sink
        t_map_answer e;
        int          hold_cnt;
        hold_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (m_tvalid && m_tready) begin
                if (expected_answers.size() == 0) begin
                    $error("result beat with no request pending: %h", m_tdata);
                    mismatches++;
                end else begin
                    e = expected_answers.pop_front();
                    if (m_tdata[0] !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, m_tdata[0]);
                        mismatches++;
                    end
                    if (m_tdata[3:1] !== e.slot) begin
                        $error("slot: expected %0d, got %0d", e.slot, m_tdata[3:1]);
                        mismatches++;
                    end
                    if (m_tdata[4] !== e.ev_valid) begin
                        $error("evicted_valid: expected %0d, got %0d", e.ev_valid, m_tdata[4]);
                        mismatches++;
                    end
                    if (m_tdata[36:5] !== e.ev_id) begin
                        $error("evicted_id: expected %h, got %h", e.ev_id, m_tdata[36:5]);
                        mismatches++;
                    end
                    if (m_tdata[68:37] !== e.active) begin
                        $error("active_id: expected %h, got %h", e.active, m_tdata[68:37]);
                        mismatches++;
                    end
                end
            end
            if (rx_hold_req) begin
                hold_cnt    = HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end else if (hold_cnt == 0 && idle_on && $urandom_range(0, 3) == 0) begin
                hold_cnt = gap_len();
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // empty cache, id zero and close of unknown ids
    task automatic test_empty_cache();
        send_request(ACT_ACTIVATE, '0, 1'b1);
        send_request(ACT_CLOSE, '0, 1'b0);
        send_request(ACT_CLOSE, 32'h0000_0005, 1'b1);
        send_request(ACT_ACTIVATE, 32'h0000_0007, 1'b0);
    endtask

    // fill all slots with extreme ids, then evict the oldest, hit, id zero
    task automatic test_fill_and_evict();
        send_request(ACT_ACTIVATE, 32'h8000_0000, 1'b1);
        send_request(ACT_ACTIVATE, 32'h7FFF_FFFF, 1'b1);
        send_request(ACT_ACTIVATE, 32'hFFFF_FFFF, 1'b1);
        send_request(ACT_ACTIVATE, 32'h0000_0001, 1'b1);
        send_request(ACT_ACTIVATE, 32'hAAAA_5555, 1'b1);
        send_request(ACT_ACTIVATE, 32'h5555_AAAA, 1'b1);
        send_request(ACT_ACTIVATE, 32'h0000_0003, 1'b1);
        send_request(ACT_ACTIVATE, 32'h0000_0004, 1'b1);
        send_request(ACT_ACTIVATE, 32'h0000_0006, 1'b1);
        send_request(ACT_ACTIVATE, 32'h7FFF_FFFF, 1'b1);
        send_request(ACT_ACTIVATE, 32'h7FFF_FFFF, 1'b0);
        send_request(ACT_ACTIVATE, '0, 1'b1);
        send_request(ACT_ACTIVATE, 32'h1234_5678, 1'b0);
    endtask

    // close leaves the active id; reactivating it is then a no-op
    task automatic test_close();
        send_request(ACT_CLOSE, 32'hFFFF_FFFF, 1'b0);
        send_request(ACT_CLOSE, 32'h7FFF_FFFF, 1'b1);
        send_request(ACT_CLOSE, 32'h0BAD_0BAD, 1'b1);
        send_request(ACT_ACTIVATE, 32'h7FFF_FFFF, 1'b1);
        send_request(ACT_ACTIVATE, 32'hFFFF_FFFF, 1'b1);
        send_request(ACT_ACTIVATE, 32'h7FFF_FFFF, 1'b1);
        send_request(ACT_CLOSE, '0, 1'b1);
    endtask

    task automatic test_random_traffic(input int count);
        t_id     pool[POOL_SIZE];
        t_id     id;
        t_action act;
        logic    ok;
        int      r;
        foreach (pool[k]) pool[k] = fresh_id();
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 39) begin
                pool[$urandom_range(0, POOL_SIZE - 1)] = fresh_id();
            end
            r   = $urandom_range(0, 99);
            ok  = ($urandom_range(0, 99) < 85);
            act = ACT_ACTIVATE;
            id  = ($urandom_range(0, 2) != 0) ? pool[$urandom_range(0, 5)]
                                              : pool[$urandom_range(0, POOL_SIZE - 1)];
            if (r < 12) begin
                act = ACT_CLOSE;
            end else if (r < 16) begin
                act = t_action'($urandom_range(0, 1));
                id  = '0;
            end else if (r < 22) begin
                act = t_action'($urandom_range(0, 1));
                id  = $urandom();
            end else if (r < 28) begin
                id = cur_map;
            end
            send_request(act, id, ok);
        end
    endtask

    // sink stalls for a long stretch while requests keep coming
    task automatic test_backpressure();
        idle_on     = 1'b0;
        rx_hold_req = 1'b1;
        test_random_traffic(24);
        idle_on = 1'b1;
    endtask

    initial begin
        flush_cache();
        use_stamp = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_cache();
        test_fill_and_evict();
        test_close();
        test_random_traffic(220);
        idle_on = 1'b0;
        test_random_traffic(100);
        idle_on = 1'b1;
        test_backpressure();
        test_random_traffic(60);

        s_tvalid <= 1'b0;
        while (expected_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

>>> sim.f
src/lomc_pkg.sv
src/lomc_ram.sv
src/lomc_scan.sv
src/lru_open_map_cache.sv
sim/tb.sv
